@@ design/tpsa_pkg.sv @@
// tpsa_pkg: shared types for the two-pool server allocator.
// Holds the pool size, the beat payload structs and the controller state enum.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpsa_pkg;

  localparam int unsigned MaxServers = 256;
  localparam int unsigned IdW        = $clog2(MaxServers);
  localparam int unsigned CountW     = $clog2(MaxServers + 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_RD2,
    S_UNLK,
    S_WP,
    S_WN,
    S_WT,
    S_DONE
  } tpsa_state_e;

  typedef struct packed {
    logic           mode;
    logic [IdW-1:0] target_id;
    logic           wanted_class;
  } tpsa_in_t;

  typedef struct packed {
    logic              status;
    logic [IdW-1:0]    granted_id;
    logic              class_changed;
    logic [CountW-1:0] busy_first_class;
    logic [CountW-1:0] busy_second_class;
  } tpsa_out_t;

  localparam logic MODE_REQ  = 1'b0;
  localparam logic MODE_FREE = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FAIL   = 1'b1;

endpackage
`default_nettype wire

@@ design/tpsa_node_mem.sv @@
// tpsa_node_mem: single-port node store with bit-masked writes.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tpsa_node_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 20
) (
  input  wire logic          clk_i,
  input  wire logic          re_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [DW-1:0] wmask_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < int'(DW); b++) begin
        if (wmask_i[b]) begin
          mem[addr_i][b] <= wdata_i[b];
        end
      end
    end else if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

@@ design/two_pool_server_allocator.sv @@
// two_pool_server_allocator: top level, list control and result register.
// Depends on tpsa_pkg and tpsa_node_mem.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i in_ready_o in_data_i  | item in
//  out     | out_valid_o out_ready_i out_data_o | result out
//  cfg     | cfg_we_i cfg_data_i              | count write
//
// One item at a time through a single-port node memory. A grant reads its node
// (and a list head if that node is busy), then writes the unlinked node and the
// links of its old neighbours. A free reads its node, then writes it back to its
// class tail and links any old tail to it. Out-of-range ids fail with no access.
// Reset and every count write start an init sweep over all MAX_SERVERS nodes that
// rebuilds the class 0 list; no beat is taken meanwhile. A new beat is taken
// only once the previous result beat is gone or leaving.
`timescale 1ns / 1ps
`default_nettype none
module two_pool_server_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tpsa_pkg::tpsa_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output tpsa_pkg::tpsa_out_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tpsa_pkg::CountW-1:0]   cfg_data_i
);

  localparam int unsigned MAX_SERVERS = tpsa_pkg::MaxServers;
  localparam int unsigned LW = $clog2(MAX_SERVERS + 1);  // link / count width
  localparam int unsigned IW = $clog2(MAX_SERVERS);      // node index width
  localparam int unsigned DW = 2 + 2 * LW;               // {busy, cls, next, prev}
  localparam logic [LW-1:0] NIL  = LW'(MAX_SERVERS);
  localparam logic [LW-1:0] LAST = LW'(MAX_SERVERS - 1);

  tpsa_pkg::tpsa_state_e state_q, state_d;

  tpsa_pkg::tpsa_in_t req_q;
  logic [LW-1:0] active_q, init_q, head_q [2], tail_q [2], busy_q [2];
  logic [LW-1:0] p_q, nx_q;
  logic [IW-1:0] pick_q;
  logic          status_q, changed_q;
  logic          out_valid_q;
  tpsa_pkg::tpsa_out_t out_q;

  // node memory port
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_addr;
  logic [DW-1:0] mem_wdata, mem_wmask, mem_rdata;

  tpsa_node_mem #(.DEPTH(MAX_SERVERS), .AW(IW), .DW(DW)) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .wmask_i(mem_wmask),
    .rdata_o(mem_rdata)
  );

  logic          rd_busy, rd_cls;
  logic [LW-1:0] rd_next, rd_prev;
  assign rd_busy = mem_rdata[DW-1];
  assign rd_cls  = mem_rdata[DW-2];
  assign rd_next = mem_rdata[2*LW-1:LW];
  assign rd_prev = mem_rdata[LW-1:0];

  logic          accept, in_range, want, alt_ok, want_ok, frc;
  logic [LW-1:0] sid_l, cfg_clamped, init_nx, init_pv;
  logic [31:0]   cfg_wide;

  assign in_ready_o = (state_q == tpsa_pkg::S_IDLE) && !(out_valid_q && !out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign sid_l      = LW'(req_q.target_id);
  assign in_range   = 32'(req_q.target_id) < 32'(active_q);
  assign want       = req_q.wanted_class;
  assign want_ok    = head_q[want] != NIL;
  assign alt_ok     = head_q[!want] != NIL;
  assign frc        = rd_cls;

  // count write clamp: 0 -> 1, above the pool -> pool size
  assign cfg_wide    = 32'(cfg_data_i);
  assign cfg_clamped = (cfg_wide == 32'd0) ? LW'(1) :
                       (cfg_wide > 32'(MAX_SERVERS)) ? NIL : LW'(cfg_wide);

  // init sweep links; entries past the active count get null links
  assign init_nx = (init_q + LW'(1) < active_q) ? init_q + LW'(1) : NIL;
  assign init_pv = (init_q == '0 || init_q >= active_q) ? NIL : init_q - LW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpsa_pkg::S_INIT: if (init_q == LAST) state_d = tpsa_pkg::S_IDLE;
      tpsa_pkg::S_IDLE: if (accept) state_d = tpsa_pkg::S_RD;
      tpsa_pkg::S_RD:   state_d = in_range ? tpsa_pkg::S_CHK : tpsa_pkg::S_DONE;
      tpsa_pkg::S_CHK: begin
        if (req_q.mode == tpsa_pkg::MODE_REQ) begin
          priority if (!rd_busy)          state_d = tpsa_pkg::S_UNLK;
          else if (want_ok || alt_ok)     state_d = tpsa_pkg::S_RD2;
          else                            state_d = tpsa_pkg::S_DONE;
        end else begin
          if (rd_busy && tail_q[frc] != NIL) state_d = tpsa_pkg::S_WT;
          else                               state_d = tpsa_pkg::S_DONE;
        end
      end
      tpsa_pkg::S_RD2:  state_d = tpsa_pkg::S_UNLK;
      tpsa_pkg::S_UNLK: state_d = tpsa_pkg::S_WP;
      tpsa_pkg::S_WP:   state_d = tpsa_pkg::S_WN;
      tpsa_pkg::S_WN:   state_d = tpsa_pkg::S_DONE;
      tpsa_pkg::S_WT:   state_d = tpsa_pkg::S_DONE;
      tpsa_pkg::S_DONE: state_d = tpsa_pkg::S_IDLE;
      default:          state_d = tpsa_pkg::S_INIT;
    endcase
    if (cfg_we_i) state_d = tpsa_pkg::S_INIT;
  end

  // memory port drive
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    mem_wmask = '0;
    unique case (state_q)
      tpsa_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = init_q[IW-1:0];
        mem_wdata = {1'b0, 1'b0, init_nx, init_pv};
        mem_wmask = '1;
      end
      tpsa_pkg::S_RD: begin
        mem_re   = in_range;
        mem_addr = IW'(req_q.target_id);
      end
      tpsa_pkg::S_CHK: begin
        if (req_q.mode == tpsa_pkg::MODE_FREE && rd_busy) begin
          // back to the tail of its class list; class kept
          mem_we    = 1'b1;
          mem_addr  = IW'(req_q.target_id);
          mem_wdata = {1'b0, 1'b0, NIL, tail_q[frc]};
          mem_wmask = {1'b1, 1'b0, {LW{1'b1}}, {LW{1'b1}}};
        end
      end
      tpsa_pkg::S_RD2: begin
        mem_re   = 1'b1;
        mem_addr = pick_q;
      end
      tpsa_pkg::S_UNLK: begin
        mem_we    = 1'b1;
        mem_addr  = pick_q;
        mem_wdata = {1'b1, want, NIL, NIL};
        mem_wmask = '1;
      end
      tpsa_pkg::S_WP: begin
        mem_we    = p_q != NIL;
        mem_addr  = p_q[IW-1:0];
        mem_wdata = {2'b00, nx_q, {LW{1'b0}}};
        mem_wmask = {2'b00, {LW{1'b1}}, {LW{1'b0}}};
      end
      tpsa_pkg::S_WN: begin
        mem_we    = nx_q != NIL;
        mem_addr  = nx_q[IW-1:0];
        mem_wdata = {2'b00, {LW{1'b0}}, p_q};
        mem_wmask = {2'b00, {LW{1'b0}}, {LW{1'b1}}};
      end
      tpsa_pkg::S_WT: begin
        mem_we    = 1'b1;
        mem_addr  = p_q[IW-1:0];
        mem_wdata = {2'b00, sid_l, {LW{1'b0}}};
        mem_wmask = {2'b00, {LW{1'b1}}, {LW{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpsa_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // list heads, tails, busy counts, sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= NIL;
      init_q    <= '0;
      head_q[0] <= '0;
      tail_q[0] <= LAST;
      head_q[1] <= NIL;
      tail_q[1] <= NIL;
      busy_q[0] <= '0;
      busy_q[1] <= '0;
    end else if (cfg_we_i) begin
      active_q  <= cfg_clamped;
      init_q    <= '0;
      head_q[0] <= '0;
      tail_q[0] <= cfg_clamped - LW'(1);
      head_q[1] <= NIL;
      tail_q[1] <= NIL;
      busy_q[0] <= '0;
      busy_q[1] <= '0;
    end else begin
      if (state_q == tpsa_pkg::S_INIT) init_q <= init_q + LW'(1);
      if (state_q == tpsa_pkg::S_CHK && req_q.mode == tpsa_pkg::MODE_FREE && rd_busy) begin
        tail_q[frc] <= sid_l;
        if (tail_q[frc] == NIL) head_q[frc] <= sid_l;
        if (busy_q[frc] != '0) busy_q[frc] <= busy_q[frc] - LW'(1);
      end
      if (state_q == tpsa_pkg::S_UNLK) begin
        // counted under the new class
        busy_q[want] <= busy_q[want] + LW'(1);
        if (rd_prev == NIL) head_q[rd_cls] <= rd_next;
        if (rd_next == NIL) tail_q[rd_cls] <= rd_prev;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tpsa_pkg::S_IDLE: begin
        if (accept) begin
          req_q     <= in_data_i;
          status_q  <= tpsa_pkg::ST_FAIL;
          changed_q <= 1'b0;
          pick_q    <= IW'(in_data_i.target_id);
        end
      end
      tpsa_pkg::S_CHK: begin
        if (req_q.mode == tpsa_pkg::MODE_REQ) begin
          if (rd_busy) pick_q <= want_ok ? head_q[want][IW-1:0] : head_q[!want][IW-1:0];
        end else if (rd_busy) begin
          status_q <= tpsa_pkg::ST_OK;
          p_q      <= tail_q[frc];
        end
      end
      tpsa_pkg::S_UNLK: begin
        p_q       <= rd_prev;
        nx_q      <= rd_next;
        changed_q <= rd_cls != want;
        status_q  <= tpsa_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tpsa_pkg::S_DONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tpsa_pkg::S_DONE) begin
      out_q.status            <= status_q;
      out_q.granted_id        <= (status_q == tpsa_pkg::ST_OK &&
                                  req_q.mode == tpsa_pkg::MODE_REQ) ?
                                 tpsa_pkg::IdW'(pick_q) : req_q.target_id;
      out_q.class_changed     <= changed_q;
      out_q.busy_first_class  <= tpsa_pkg::CountW'(busy_q[0]);
      out_q.busy_second_class <= tpsa_pkg::CountW'(busy_q[1]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ bench/two_pool_server_allocator_tb.sv @@
// two_pool_server_allocator_tb: self-checking bench for the two-pool server allocator.
// Drives request/free beats with random idling on both sides and checks each result beat.
// Depends on tpsa_pkg and the two_pool_server_allocator RTL.
`timescale 1ns / 1ps
module two_pool_server_allocator_tb;

  localparam int unsigned NSRV     = tpsa_pkg::MaxServers;
  localparam int unsigned NIL      = NSRV;
  localparam int unsigned CYC_MAX  = 400000;
  // Settle time before a count write and before the end of the run.
  localparam int unsigned SETTLE   = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  tpsa_pkg::tpsa_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  tpsa_pkg::tpsa_out_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  two_pool_server_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Pool shadow: busy/class bits, doubly linked free lists, counters.
  // ---------------------------------------------------------------------
  bit          srv_busy [NSRV];
  bit          srv_cls  [NSRV];
  int unsigned nxt [NSRV];
  int unsigned prv [NSRV];
  int unsigned head [2];
  int unsigned tail [2];
  int unsigned nfree [2];
  int unsigned nbusy [2];
  int unsigned pool_size;

  tpsa_pkg::tpsa_out_t pending_results [$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_grants = 0;
  int unsigned n_frees = 0;
  int unsigned n_fails = 0;
  int unsigned n_writes = 0;
  int unsigned cycles = 0;

  // Rebuild the shadow pool after reset or a count write (0 -> 1, clamp high).
  function automatic void pool_rebuild(int unsigned value);
    int unsigned n;
    n = (value == 0) ? 1 : ((value > NSRV) ? NSRV : value);
    pool_size = n;
    for (int i = 0; i < NSRV; i++) begin
      srv_busy[i] = 1'b0;
      srv_cls[i]  = 1'b0;
      nxt[i] = NIL;
      prv[i] = NIL;
    end
    for (int unsigned i = 0; i < n; i++) begin
      nxt[i] = (i + 1 < n) ? i + 1 : NIL;
      prv[i] = (i == 0) ? NIL : i - 1;
    end
    head[0] = 0;     tail[0] = n - 1;
    head[1] = NIL;   tail[1] = NIL;
    nfree[0] = n;    nfree[1] = 0;
    nbusy[0] = 0;    nbusy[1] = 0;
  endfunction

  function automatic void list_remove(int unsigned c, int unsigned node);
    int unsigned p, nx;
    p  = prv[node];
    nx = nxt[node];
    if (p < NIL) nxt[p] = nx;
    else head[c] = nx;
    if (nx < NIL) prv[nx] = p;
    else tail[c] = p;
    prv[node] = NIL;
    nxt[node] = NIL;
    if (nfree[c] > 0) nfree[c]--;
  endfunction

  function automatic void list_push_tail(int unsigned c, int unsigned node);
    int unsigned t;
    t = tail[c];
    prv[node] = t;
    nxt[node] = NIL;
    if (t < NIL) nxt[t] = node;
    else head[c] = node;
    tail[c] = node;
    nfree[c]++;
  endfunction

  // Predict one result beat and advance the shadow pool.
  function automatic tpsa_pkg::tpsa_out_t allocate_or_release(tpsa_pkg::tpsa_in_t it);
    tpsa_pkg::tpsa_out_t r;
    int unsigned sid, want, pick, oldc, c;
    sid  = it.target_id;
    want = it.wanted_class;
    r = '0;
    r.status     = tpsa_pkg::ST_FAIL;
    r.granted_id = it.target_id;
    if (sid < pool_size) begin
      if (it.mode == tpsa_pkg::MODE_REQ) begin
        pick = NIL;
        if (!srv_busy[sid]) pick = sid;
        else if (head[want] < NIL) pick = head[want];
        else if (head[want ^ 1] < NIL) pick = head[want ^ 1];
        if (pick < NIL) begin
          oldc = srv_cls[pick];
          list_remove(oldc, pick);
          srv_busy[pick] = 1'b1;
          r.class_changed = (oldc != want);
          srv_cls[pick] = want[0];
          nbusy[want]++;
          r.granted_id = pick[7:0];
          r.status = tpsa_pkg::ST_OK;
        end
      end else if (srv_busy[sid]) begin
        c = srv_cls[sid];
        srv_busy[sid] = 1'b0;
        if (nbusy[c] > 0) nbusy[c]--;
        list_push_tail(c, sid);
        r.status = tpsa_pkg::ST_OK;
      end
    end
    r.busy_first_class  = nbusy[0][8:0];
    r.busy_second_class = nbusy[1][8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------
  // Send one beat after a random gap; hold valid and payload until taken.
  // With no gap, valid stays up and the next payload follows at once.
  // When fixed is set, the typed-in result is checked against the predictor
  // too, so a slip in either shows up.
  task automatic send_beat(tpsa_pkg::tpsa_in_t it, bit fixed,
                           tpsa_pkg::tpsa_out_t want_r);
    tpsa_pkg::tpsa_out_t p;
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    p = allocate_or_release(it);
    if (fixed && p !== want_r) begin
      $display("%0t: table/predictor disagree exp=%h pred=%h", $time, want_r, p);
      n_errors++;
    end
    if (p.status == tpsa_pkg::ST_FAIL) n_fails++;
    else if (it.mode == tpsa_pkg::MODE_REQ) n_grants++;
    else n_frees++;
    pending_results.push_back(fixed ? want_r : p);
  endtask

  // Count write: only once the block has drained.
  task automatic write_count(logic [8:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_rebuild(value);
    n_writes++;
  endtask

  function automatic tpsa_pkg::tpsa_in_t mk(logic m, int unsigned id, logic w);
    tpsa_pkg::tpsa_in_t it;
    it.mode = m;
    it.target_id = id[7:0];
    it.wanted_class = w;
    return it;
  endfunction

  function automatic tpsa_pkg::tpsa_out_t res(logic s, int unsigned id, logic ch,
                                              int unsigned b0, int unsigned b1);
    tpsa_pkg::tpsa_out_t r;
    r.status = s;
    r.granted_id = id[7:0];
    r.class_changed = ch;
    r.busy_first_class = b0[8:0];
    r.busy_second_class = b1[8:0];
    return r;
  endfunction

  // Directed rows; fixed=1 rows carry a result read straight off the spec.
  typedef struct {
    tpsa_pkg::tpsa_in_t  beat;
    bit                  fixed;
    tpsa_pkg::tpsa_out_t result;
  } dir_row_t;

  // ---------------------------------------------------------------------
  // Receiver side: random stalls, in-order compare with the oldest entry.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat act=%h", $time, out_data_o);
          n_errors++;
        end else begin
          tpsa_pkg::tpsa_out_t e;
          e = pending_results.pop_front();
          if (out_data_o.status !== e.status)
            $display("%0t: status exp=%0d act=%0d", $time, e.status, out_data_o.status);
          if (out_data_o.granted_id !== e.granted_id)
            $display("%0t: granted_id exp=%0d act=%0d", $time, e.granted_id,
                     out_data_o.granted_id);
          if (out_data_o.class_changed !== e.class_changed)
            $display("%0t: class_changed exp=%0d act=%0d", $time, e.class_changed,
                     out_data_o.class_changed);
          if (out_data_o.busy_first_class !== e.busy_first_class)
            $display("%0t: busy_first_class exp=%0d act=%0d", $time,
                     e.busy_first_class, out_data_o.busy_first_class);
          if (out_data_o.busy_second_class !== e.busy_second_class)
            $display("%0t: busy_second_class exp=%0d act=%0d", $time,
                     e.busy_second_class, out_data_o.busy_second_class);
          if (out_data_o !== e) n_errors++;
        end
      end
    end
  end

  // Ready: per beat an optional random stall, then held until the beat goes.
  initial begin : ready_gen
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random phase for one pool size: mostly grant/free traffic on live ids,
  // some out-of-range ids and frees of idle servers.
  task automatic random_phase(int unsigned items);
    tpsa_pkg::tpsa_in_t it;
    int unsigned id;
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) == 0) id = $urandom_range(0, 255);
      else id = $urandom_range(0, pool_size - 1);
      it = mk(($urandom_range(0, 99) < 45), id, 1'($urandom_range(0, 1)));
      send_beat(it, 1'b0, '0);
    end
  endtask

  initial begin : main
    dir_row_t rows [$];
    pool_rebuild(NSRV);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: full pool, everything class 0.
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 0, 1'b0), 1, res(tpsa_pkg::ST_OK, 0, 0, 1, 0)});
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 255, 1'b1), 1,
                     res(tpsa_pkg::ST_OK, 255, 1, 1, 1)});
    // Preferred busy: head of class 0 list (server 1), class changes.
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 0, 1'b1), 1, res(tpsa_pkg::ST_OK, 1, 1, 1, 2)});
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 0, 1'b0), 1, res(tpsa_pkg::ST_OK, 0, 0, 0, 2)});
    // Free of an idle server fails.
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 0, 1'b1), 1,
                     res(tpsa_pkg::ST_FAIL, 0, 0, 0, 2)});
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 255, 1'b0), 1,
                     res(tpsa_pkg::ST_OK, 255, 0, 0, 1)});
    // 255 now sits in the class 1 list; a busy preferred with want=1 takes it.
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 1, 1'b1), 0, '0});
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 1, 1'b0), 0, '0});
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 128, 1'b0), 0, '0});
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 128, 1'b1), 0, '0});
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].result);
    rows.delete();

    // Single-server pool: out-of-range ids and the empty pool.
    write_count(9'd1);
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 1, 1'b0), 1,
                     res(tpsa_pkg::ST_FAIL, 1, 0, 0, 0)});
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 255, 1'b0), 1,
                     res(tpsa_pkg::ST_FAIL, 255, 0, 0, 0)});
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 0, 1'b1), 1, res(tpsa_pkg::ST_OK, 0, 1, 0, 1)});
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 0, 1'b0), 1,
                     res(tpsa_pkg::ST_FAIL, 0, 0, 0, 1)});
    rows.push_back('{mk(tpsa_pkg::MODE_FREE, 0, 1'b0), 1, res(tpsa_pkg::ST_OK, 0, 0, 0, 0)});
    // Back from the class 1 list into class 0.
    rows.push_back('{mk(tpsa_pkg::MODE_REQ, 0, 1'b0), 1, res(tpsa_pkg::ST_OK, 0, 1, 1, 0)});
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].fixed, rows[i].result);
    rows.delete();

    // Count write of 0 acts as 1; above the maximum clamps to 256.
    write_count(9'd0);
    send_beat(mk(tpsa_pkg::MODE_REQ, 1, 1'b0), 1, res(tpsa_pkg::ST_FAIL, 1, 0, 0, 0));
    send_beat(mk(tpsa_pkg::MODE_REQ, 0, 1'b0), 1, res(tpsa_pkg::ST_OK, 0, 0, 1, 0));
    write_count(9'd511);
    send_beat(mk(tpsa_pkg::MODE_REQ, 255, 1'b0), 1, res(tpsa_pkg::ST_OK, 255, 0, 1, 0));

    // Random phases across pool sizes, small ones to hit exhaustion often.
    write_count(9'd2);    random_phase(60);
    write_count(9'd5);    random_phase(100);
    write_count(9'd16);   random_phase(150);
    write_count(9'd256);  random_phase(180);
    write_count(9'd3);    random_phase(80);
    write_count(9'($urandom_range(1, 256))); random_phase(130);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d grants, %0d frees, %0d failures over %0d count writes",
             n_grants, n_frees, n_fails, n_writes);
    $display("%0d result beats checked, %0d mismatching", n_results, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
